@@ hw/rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the linear contrast stretch block.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int unsigned LCS_CHANNELS    = 3;
    localparam int unsigned LCS_PIX_W       = 8;
    localparam int unsigned LCS_NUM_W       = 2 * LCS_PIX_W;
    localparam int unsigned LCS_DIV_STEPS   = LCS_PIX_W;
    localparam int unsigned LCS_STEP_W      = $clog2(LCS_DIV_STEPS);
    localparam int unsigned LCS_QUEUE_DEPTH = 4;

    localparam logic [LCS_PIX_W-1:0] LCS_FULL_SCALE = 8'd255;
    localparam logic [LCS_STEP_W-1:0] LCS_LAST_STEP = LCS_STEP_W'(LCS_DIV_STEPS - 1);

    // Item kinds
    localparam logic LCS_KIND_GATHER  = 1'b0;
    localparam logic LCS_KIND_STRETCH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic       frame_start;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } lcs_pixel_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [2:0] flat_mask;
    } lcs_result_t;

    // One division request per stretch pixel: numerator and divisor per channel
    typedef struct packed {
        logic [LCS_CHANNELS-1:0][LCS_NUM_W-1:0] num;
        logic [LCS_CHANNELS-1:0][LCS_PIX_W-1:0] den;
        logic [LCS_CHANNELS-1:0]                flat_mask;
    } lcs_job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lcs_back_status_t;

    typedef enum logic {
        LCS_BACK_IDLE,
        LCS_BACK_DIV
    } lcs_back_state_t;

endpackage

@@ hw/rtl/lcs_front.sv @@
// ----------------------------------------------------------------------------
// lcs_front
// Accept pixels, track per-channel minimum and maximum, and turn each stretch
// pixel into a division request.
// ----------------------------------------------------------------------------
module lcs_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lcs_pkg::lcs_pixel_t pixel,
    input  logic               queue_full,
    output logic               job_push,
    output lcs_pkg::lcs_job_t  job
);

    logic [lcs_pkg::LCS_CHANNELS-1:0][lcs_pkg::LCS_PIX_W-1:0] lo_reg;
    logic [lcs_pkg::LCS_CHANNELS-1:0][lcs_pkg::LCS_PIX_W-1:0] lo_next;
    logic [lcs_pkg::LCS_CHANNELS-1:0][lcs_pkg::LCS_PIX_W-1:0] hi_reg;
    logic [lcs_pkg::LCS_CHANNELS-1:0][lcs_pkg::LCS_PIX_W-1:0] hi_next;
    logic [lcs_pkg::LCS_CHANNELS-1:0][lcs_pkg::LCS_PIX_W-1:0] px;
    logic accept;
    logic gather;

    assign px[0]  = pixel.red_in;
    assign px[1]  = pixel.green_in;
    assign px[2]  = pixel.blue_in;
    assign accept = push && !queue_full;
    assign gather = accept && (pixel.kind == lcs_pkg::LCS_KIND_GATHER);
    assign job_push = accept && (pixel.kind == lcs_pkg::LCS_KIND_STRETCH);

    // Fold the pixel into the running extremes; restart them on frame start
    always_comb
    begin
        logic [lcs_pkg::LCS_PIX_W-1:0] base_lo;
        logic [lcs_pkg::LCS_PIX_W-1:0] base_hi;
        lo_next = lo_reg;
        hi_next = hi_reg;
        for (int c = 0; c < lcs_pkg::LCS_CHANNELS; c++)
        begin
            base_lo = pixel.frame_start ? lcs_pkg::LCS_FULL_SCALE : lo_reg[c];
            base_hi = pixel.frame_start ? '0 : hi_reg[c];
            if (gather)
            begin
                lo_next[c] = (px[c] < base_lo) ? px[c] : base_lo;
                hi_next[c] = (px[c] > base_hi) ? px[c] : base_hi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < lcs_pkg::LCS_CHANNELS; c++)
            begin
                lo_reg[c] <= lcs_pkg::LCS_FULL_SCALE;
                hi_reg[c] <= '0;
            end
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Classify each channel; clamped and flat channels become trivial divisions
    always_comb
    begin
        logic [lcs_pkg::LCS_PIX_W-1:0] diff;
        job = '0;
        for (int c = 0; c < lcs_pkg::LCS_CHANNELS; c++)
        begin
            diff = px[c] - lo_reg[c];
            job.den[c] = lcs_pkg::LCS_PIX_W'(1);
            job.num[c] = '0;
            if (hi_reg[c] <= lo_reg[c])
            begin
                job.flat_mask[c] = 1'b1;
            end
            else if (px[c] <= lo_reg[c])
            begin
                job.num[c] = '0;
            end
            else if (px[c] >= hi_reg[c])
            begin
                job.num[c] = {{lcs_pkg::LCS_PIX_W{1'b0}}, lcs_pkg::LCS_FULL_SCALE};
            end
            else
            begin
                // 255 * diff as (diff << 8) - diff
                job.num[c] = {diff, {lcs_pkg::LCS_PIX_W{1'b0}}}
                           - {{lcs_pkg::LCS_PIX_W{1'b0}}, diff};
                job.den[c] = hi_reg[c] - lo_reg[c];
            end
        end
    end

endmodule

@@ hw/rtl/lcs_queue.sv @@
// ----------------------------------------------------------------------------
// lcs_queue
// Short register queue of division requests between front and back.
// ----------------------------------------------------------------------------
module lcs_queue
#(
    parameter int unsigned DEPTH = lcs_pkg::LCS_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  lcs_pkg::lcs_job_t wr_job,
    output logic              full,
    input  logic              rd_en,
    output lcs_pkg::lcs_job_t rd_job,
    output logic              empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lcs_pkg::lcs_job_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic do_wr;
    logic do_rd;

    assign full   = (cnt_reg == FULL_CNT);
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

@@ hw/rtl/lcs_back.sv @@
// ----------------------------------------------------------------------------
// lcs_back
// Run one request through three radix-2 restoring dividers, one per channel,
// and hold the finished result until it is taken.
// ----------------------------------------------------------------------------
module lcs_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_empty,
    input  lcs_pkg::lcs_job_t         job,
    output logic                      job_pop,
    input  logic                      pop,
    output logic                      empty,
    output lcs_pkg::lcs_result_t      result,
    output lcs_pkg::lcs_back_status_t status
);

    localparam int unsigned CH = lcs_pkg::LCS_CHANNELS;
    localparam int unsigned PW = lcs_pkg::LCS_PIX_W;

    lcs_pkg::lcs_back_state_t state_reg;
    lcs_pkg::lcs_back_state_t state_next;
    logic [lcs_pkg::LCS_STEP_W-1:0] step_reg;
    logic [lcs_pkg::LCS_STEP_W-1:0] step_next;
    logic [CH-1:0][PW-1:0] rem_reg;
    logic [CH-1:0][PW-1:0] rem_next;
    logic [CH-1:0][PW-1:0] quo_reg;
    logic [CH-1:0][PW-1:0] quo_next;
    logic [CH-1:0][PW-1:0] den_reg;
    logic [CH-1:0]         mask_reg;
    lcs_pkg::lcs_result_t  res_reg;
    lcs_pkg::lcs_result_t  res_next;
    logic res_valid_reg;
    logic res_valid_next;
    logic out_free;
    logic load;
    logic finish;

    assign out_free = !res_valid_reg || pop;
    assign empty    = !res_valid_reg;
    assign result   = res_reg;
    assign job_pop  = load;
    assign status.busy = (state_reg == lcs_pkg::LCS_BACK_DIV);
    assign status.done = finish;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcs_pkg::LCS_BACK_IDLE:
            begin
                if (!job_empty && out_free)
                begin
                    state_next = lcs_pkg::LCS_BACK_DIV;
                end
            end
            lcs_pkg::LCS_BACK_DIV:
            begin
                if (step_reg == lcs_pkg::LCS_LAST_STEP)
                begin
                    state_next = lcs_pkg::LCS_BACK_IDLE;
                end
            end
            default:
            begin
                state_next = lcs_pkg::LCS_BACK_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        load   = 1'b0;
        finish = 1'b0;
        case (state_reg)
            lcs_pkg::LCS_BACK_IDLE:
            begin
                load = !job_empty && out_free;
            end
            lcs_pkg::LCS_BACK_DIV:
            begin
                finish = (step_reg == lcs_pkg::LCS_LAST_STEP);
            end
            default:
            begin
                load   = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    // One quotient bit per channel per cycle
    always_comb
    begin
        logic [PW:0] trial;
        logic        ge;
        for (int c = 0; c < CH; c++)
        begin
            trial = {rem_reg[c], quo_reg[c][PW-1]};
            ge    = (trial >= {1'b0, den_reg[c]});
            rem_next[c] = ge ? PW'(trial - {1'b0, den_reg[c]}) : trial[PW-1:0];
            quo_next[c] = {quo_reg[c][PW-2:0], ge};
        end
    end

    assign step_next = load ? '0 : step_reg + lcs_pkg::LCS_STEP_W'(1);

    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
        if (finish)
        begin
            res_next.red_out   = quo_next[0];
            res_next.green_out = quo_next[1];
            res_next.blue_out  = quo_next[2];
            res_next.flat_mask = mask_reg;
            res_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcs_pkg::LCS_BACK_IDLE;
            res_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (load)
        begin
            for (int c = 0; c < CH; c++)
            begin
                rem_reg[c] <= job.num[c][2*PW-1:PW];
                quo_reg[c] <= job.num[c][PW-1:0];
                den_reg[c] <= job.den[c];
            end
            mask_reg <= job.flat_mask;
        end
        else if (state_reg == lcs_pkg::LCS_BACK_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

@@ hw/rtl/linear_contrast_stretch.sv @@
// ----------------------------------------------------------------------------
// linear_contrast_stretch
// Per-channel min-max contrast stretch of RGB pixels over two passes.
// ----------------------------------------------------------------------------
// Send the image twice. Gather pixels (kind 0) update the running minimum and
// maximum of each channel and give no result; set frame_start on the first
// gather pixel of a frame to restart them. Stretch pixels (kind 1) each give
// one result, floor(255*(p-min)/(max-min)) per channel, clamped to 0..255;
// a channel whose maximum is not above its minimum gives 0 and sets its
// flat_mask bit. Statistics are applied in arrival order, so a stretch pixel
// sees exactly the gathers that were pushed before it. Gather pixels are
// taken one per clock while the request queue has room. In the back end a
// stretch pixel first loads its request and then runs 8 radix-2 steps of the
// three per-channel restoring dividers; the back end takes no new request
// until that division is done and the result register is free or being
// taken. Up to QUEUE_DEPTH stretch requests wait in the queue between the
// front end and the dividers; push is refused (full) while that queue is full.
// ----------------------------------------------------------------------------
module linear_contrast_stretch
#(
    parameter int unsigned QUEUE_DEPTH = lcs_pkg::LCS_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  lcs_pkg::lcs_pixel_t  pixel,
    output logic                 empty,
    input  logic                 pop,
    output lcs_pkg::lcs_result_t result
);

    lcs_pkg::lcs_job_t         wr_job;
    lcs_pkg::lcs_job_t         rd_job;
    lcs_pkg::lcs_back_status_t back_status;
    logic job_push;
    logic job_pop;
    logic job_empty;

    // Front end: statistics and request building
    lcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pixel      (pixel),
        .queue_full (full),
        .job_push   (job_push),
        .job        (wr_job)
    );

    // Decouple the front end from the dividers
    lcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (wr_job),
        .full   (full),
        .rd_en  (job_pop),
        .rd_job (rd_job),
        .empty  (job_empty)
    );

    // Back end: dividers and the result register
    lcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (rd_job),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .status    (back_status)
    );

`ifndef SYNTH
    // A flat channel always reads zero
    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((!result.flat_mask[0] || result.red_out == '0)
                 && (!result.flat_mask[1] || result.green_out == '0)
                 && (!result.flat_mask[2] || result.blue_out == '0)))
        else $error("flat channel with nonzero output");

    // A finished division always lands in the result register
    a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.done |=> !empty)
        else $error("finished result not presented");

    // A result only leaves when it is taken
    a_empty_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result dropped without pop");

    // Dividers only finish while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.done |-> back_status.busy)
        else $error("divider finish outside busy");
`endif

endmodule
